### rtl/assert_macros.svh
// assertion macros used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check a property on every clock edge outside reset
`define ALS_CHECK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("als check failed");

// check that a condition implies a consequence outside reset
`define ALS_CHECK_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("als implication check failed");

`else

`define ALS_CHECK(name, clk, rst_n, prop)
`define ALS_CHECK_IMP(name, clk, rst_n, ante, cons)

`endif

`endif

### rtl/als_pkg.sv
// types and constants of the antialiased line stepper
package als_pkg;

  localparam int COORD_INT_BITS  = 12;
  localparam int COORD_FRAC_BITS = 4;
  localparam int SLOPE_FRAC_BITS = 12;

  localparam int COORD_W  = COORD_INT_BITS + COORD_FRAC_BITS;
  localparam int PIX_W    = COORD_INT_BITS + 1;
  localparam int COV_FRAC = 8;
  localparam int COV_W    = COV_FRAC + 1;
  localparam int FULL_COV = 1 << COV_FRAC;
  localparam int SLOPE_W  = SLOPE_FRAC_BITS + 2;
  localparam int QUO_W    = SLOPE_FRAC_BITS + 1;
  localparam int MINOR_W  = 28;
  localparam int CNT_W    = $clog2(QUO_W);

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  typedef logic [COORD_W-1:0]        coord_t;
  typedef logic [PIX_W-1:0]          pix_t;
  typedef logic [COV_W-1:0]          cov_t;
  typedef logic signed [SLOPE_W-1:0] slope_t;
  typedef logic signed [MINOR_W-1:0] minor_t;
  typedef logic [QUO_W-1:0]          quo_t;

  typedef struct packed {
    pix_t pixel_x;
    pix_t pixel_y;
    logic steep;
    cov_t coverage_first;
    cov_t coverage_second;
    logic last;
  } pair_t;

  typedef struct packed {
    logic   start;
    coord_t num;
    coord_t den;
  } div_req_t;

  typedef struct packed {
    logic done;
    quo_t quo;
  } div_rsp_t;

endpackage

### rtl/als_if.sv
// valid/ready channel interfaces for line loads and pixel pairs
interface als_in_if;
  logic                 valid;
  logic                 ready;
  logic                 func;
  als_pkg::coord_t      x_start;
  als_pkg::coord_t      y_start;
  als_pkg::coord_t      x_end;
  als_pkg::coord_t      y_end;

  modport source (output valid, func, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, func, x_start, y_start, x_end, y_end, output ready);
endinterface

interface als_out_if;
  logic           valid;
  logic           ready;
  als_pkg::pix_t  pixel_x;
  als_pkg::pix_t  pixel_y;
  logic           steep;
  als_pkg::cov_t  coverage_first;
  als_pkg::cov_t  coverage_second;
  logic           last;

  modport source (output valid, pixel_x, pixel_y, steep, coverage_first, coverage_second,
                  last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, steep, coverage_first, coverage_second,
                  last, output ready);
endinterface

### rtl/als_divider.sv
// iterative restoring divider for the gradient, one quotient bit per cycle
module als_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  als_pkg::div_req_t  req,
  output als_pkg::div_rsp_t  rsp
);

  logic                         busy_r;
  logic                         done_r;
  logic [als_pkg::CNT_W-1:0]    cnt_r;
  als_pkg::coord_t              rem_r;
  als_pkg::coord_t              den_r;
  als_pkg::quo_t                feed_r;
  als_pkg::quo_t                quo_r;

  logic [als_pkg::COORD_W:0]    trial;
  logic [als_pkg::COORD_W:0]    diff;
  logic                         ge;

  // shift in the next numerator bit and try the subtraction
  assign trial = {rem_r, feed_r[als_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = !diff[als_pkg::COORD_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // numerator is num << SLOPE_FRAC_BITS; top bits start in the remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.num >> 1;
      feed_r <= {req.num[0], {als_pkg::SLOPE_FRAC_BITS{1'b0}}};
      den_r  <= req.den;
      cnt_r  <= als_pkg::CNT_W'(als_pkg::SLOPE_FRAC_BITS);
      quo_r  <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[als_pkg::COORD_W-1:0] : trial[als_pkg::COORD_W-1:0];
      feed_r <= {feed_r[als_pkg::QUO_W-2:0], 1'b0};
      cnt_r  <= cnt_r - als_pkg::CNT_W'(1);
      quo_r  <= {quo_r[als_pkg::QUO_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

### rtl/als_endpoint.sv
// endpoint setup: rounded major pixel, minor position and end gap
module als_endpoint (
  input  als_pkg::coord_t  major,
  input  als_pkg::coord_t  minor,
  input  als_pkg::slope_t  slope,
  output als_pkg::pix_t    pix,
  output als_pkg::minor_t  minor_pos,
  output als_pkg::cov_t    gap
);

  localparam int CF     = als_pkg::COORD_FRAC_BITS;
  localparam int PROD_W = als_pkg::SLOPE_W + CF + 1;
  localparam int PAD_W  = als_pkg::MINOR_W - als_pkg::COORD_W
                          - (als_pkg::SLOPE_FRAC_BITS - CF);
  localparam logic [CF-1:0] HALF = CF'(1 << (CF - 1));

  logic [als_pkg::COORD_W:0]  a_half;
  logic [CF-1:0]              fr;
  logic signed [CF:0]         offset;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   prod_fl;

  assign a_half  = {1'b0, major} + {{(als_pkg::COORD_W + 1 - CF){1'b0}}, HALF};
  assign pix     = a_half[als_pkg::COORD_W:CF];
  assign fr      = a_half[CF-1:0];
  // distance from the endpoint to its pixel center, -7/16 .. 8/16
  assign offset  = $signed({1'b0, HALF}) - $signed({1'b0, fr});
  assign prod    = PROD_W'(slope) * PROD_W'(offset);
  assign prod_fl = prod >>> CF;

  assign minor_pos = $signed({{PAD_W{1'b0}}, minor,
                              {(als_pkg::SLOPE_FRAC_BITS - CF){1'b0}}})
                     + als_pkg::MINOR_W'(prod_fl);

  assign gap = als_pkg::COV_W'(als_pkg::FULL_COV)
               - als_pkg::COV_W'({fr, {(als_pkg::COV_FRAC - CF){1'b0}}});

endmodule

### rtl/als_pixel_emit.sv
// forms one pixel pair: coordinates and the two weighted coverages
module als_pixel_emit (
  input  als_pkg::pix_t    major,
  input  als_pkg::minor_t  minor,
  input  als_pkg::cov_t    gap,
  input  logic             steep,
  input  logic             last,
  output als_pkg::pair_t   pair
);

  localparam int SF = als_pkg::SLOPE_FRAC_BITS;

  als_pkg::pix_t                  mpix;
  logic [als_pkg::COV_FRAC-1:0]   f;
  als_pkg::cov_t                  f_inv;
  logic [2*als_pkg::COV_W-1:0]    p1;
  logic [2*als_pkg::COV_W-1:0]    p2;

  // floor of the minor position, wraps for the clipper downstream
  assign mpix  = minor[als_pkg::PIX_W+SF-1:SF];
  assign f     = minor[SF-1 -: als_pkg::COV_FRAC];
  assign f_inv = als_pkg::COV_W'(als_pkg::FULL_COV) - {1'b0, f};
  assign p1    = (2*als_pkg::COV_W)'(f_inv) * (2*als_pkg::COV_W)'(gap);
  assign p2    = (2*als_pkg::COV_W)'({1'b0, f}) * (2*als_pkg::COV_W)'(gap);

  assign pair.pixel_x         = steep ? mpix : major;
  assign pair.pixel_y         = steep ? major : mpix;
  assign pair.steep           = steep;
  assign pair.coverage_first  = p1[als_pkg::COV_FRAC +: als_pkg::COV_W];
  assign pair.coverage_second = p2[als_pkg::COV_FRAC +: als_pkg::COV_W];
  assign pair.last            = last;

endmodule

### rtl/antialiased_line_stepper_core.sv
// top level of the antialiased line stepper: setup sequencer and pixel pair stepping
//
// usage:
//  - in_ch carries transactions with func: a load transaction (func 0) gives two
//    endpoints in unsigned Q12.4; an advance transaction (func 1) asks for the next
//    pixel pair of the current segment
//  - out_ch carries one pixel pair per advance while a segment is active: first
//    pixel coordinates, steep flag, two coverages (256 is full) and a last flag
//  - after a load transaction, the next possible transaction waits for the setup:
//    the sort and diff states, the restoring divider, collecting the quotient and
//    the endpoint setup state; in_ch.ready is low meanwhile and a load produces
//    no output transaction
//  - advances are taken one per cycle while out_ch does not stall; each pair appears
//    in the output register the cycle after its transaction
//  - an advance with no active segment is consumed and gives nothing
//  - a load while a segment is active drops the old segment
//  - when out_ch stalls, the pending pair holds and in_ch.ready drops until the
//    output register frees up (it is taken in the same cycle when out_ch.ready is high)
//  - reset (rst_n low, synchronous) clears the sequencer, the active flag and
//    out_ch.valid
`include "assert_macros.svh"

module antialiased_line_stepper_core (
  input  logic          clk,
  input  logic          rst_n,
  als_in_if.sink        in_ch,
  als_out_if.source     out_ch
);

  typedef enum logic [2:0] {
    ST_RUN,
    ST_SORT,
    ST_DIFF,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_INTERIOR,
    PH_END
  } phase_t;

  localparam int PIX_W   = als_pkg::PIX_W;
  localparam int COORD_W = als_pkg::COORD_W;

  // control state
  state_t           st_r,        st_nxt;
  logic             active_r,    active_nxt;
  phase_t           phase_r,     phase_nxt;
  logic             out_valid_r, out_valid_nxt;

  // raw endpoints and ordered setup values
  als_pkg::coord_t  xs_r, ys_r, xe_r, ye_r;
  als_pkg::coord_t  a1_r, m1_r, a2_r, m2_r;
  als_pkg::coord_t  a1_nxt, m1_nxt, a2_nxt, m2_nxt;
  logic             steep_r,     steep_nxt;
  logic             neg_r,       neg_nxt;
  logic             da_zero_r,   da_zero_nxt;

  // stepping state
  als_pkg::slope_t  slope_r,      slope_nxt;
  als_pkg::pix_t    major_pos_r,  major_pos_nxt;
  als_pkg::pix_t    major_stop_r, major_stop_nxt;
  als_pkg::minor_t  minor_acc_r,  minor_acc_nxt;
  als_pkg::cov_t    start_gap_r,  start_gap_nxt;
  als_pkg::minor_t  end_minor_r,  end_minor_nxt;
  als_pkg::cov_t    end_gap_r,    end_gap_nxt;
  als_pkg::pair_t   pair_r,       pair_nxt;

  // handshake
  logic             in_ready;
  logic             in_fire;
  logic             load_fire;
  logic             adv_fire;

  // sort stage
  als_pkg::coord_t  adx, ady;
  logic             steep_c;
  als_pkg::coord_t  sa1, sm1, sa2, sm2;

  // diff stage
  als_pkg::coord_t  da_c;
  logic [COORD_W:0] dm_c;
  logic [COORD_W:0] dm_neg;
  als_pkg::coord_t  adm_c;

  // divider
  als_pkg::div_req_t div_req;
  als_pkg::div_rsp_t div_rsp;
  als_pkg::slope_t   quo_s;

  // endpoint setup
  als_pkg::pix_t    ep1_pix, ep2_pix;
  als_pkg::minor_t  ep1_minor, ep2_minor;
  als_pkg::cov_t    ep1_gap, ep2_gap;

  // pair selection
  logic             interior_ok;
  als_pkg::pix_t    em_major;
  als_pkg::minor_t  em_minor;
  als_pkg::cov_t    em_gap;
  logic             em_last;
  als_pkg::pair_t   em_pair;

  // a new transaction only when the output register is free or being drained
  assign in_ready  = (st_r == ST_RUN) && (!out_valid_r || out_ch.ready);
  assign in_fire   = in_ch.valid && in_ready;
  assign load_fire = in_fire && (in_ch.func == als_pkg::FUNC_LOAD);
  assign adv_fire  = in_fire && (in_ch.func == als_pkg::FUNC_ADVANCE);

  // major axis by slope, then order so the major coordinate rises
  always_comb begin
    adx     = (xe_r >= xs_r) ? (xe_r - xs_r) : (xs_r - xe_r);
    ady     = (ye_r >= ys_r) ? (ye_r - ys_r) : (ys_r - ye_r);
    steep_c = ady > adx;
    sa1     = steep_c ? ys_r : xs_r;
    sm1     = steep_c ? xs_r : ys_r;
    sa2     = steep_c ? ye_r : xe_r;
    sm2     = steep_c ? xe_r : ye_r;
  end

  // deltas for the divider; the minor delta never exceeds the major delta
  assign da_c   = a2_r - a1_r;
  assign dm_c   = {1'b0, m2_r} - {1'b0, m1_r};
  assign dm_neg = -dm_c;
  assign adm_c  = dm_c[COORD_W] ? dm_neg[COORD_W-1:0] : dm_c[COORD_W-1:0];

  assign div_req.start = (st_r == ST_DIFF);
  assign div_req.num   = adm_c;
  assign div_req.den   = da_c;

  als_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign quo_s = $signed({1'b0, div_rsp.quo});

  als_endpoint u_ep_start (
    .major     (a1_r),
    .minor     (m1_r),
    .slope     (slope_r),
    .pix       (ep1_pix),
    .minor_pos (ep1_minor),
    .gap       (ep1_gap)
  );

  als_endpoint u_ep_end (
    .major     (a2_r),
    .minor     (m2_r),
    .slope     (slope_r),
    .pix       (ep2_pix),
    .minor_pos (ep2_minor),
    .gap       (ep2_gap)
  );

  // which pair the next advance produces: start, interior or end endpoint
  assign interior_ok = major_pos_r < major_stop_r;

  always_comb begin
    if (phase_r == PH_START) begin
      em_major = major_pos_r;
      em_minor = minor_acc_r;
      em_gap   = start_gap_r;
      em_last  = 1'b0;
    end else if ((phase_r == PH_INTERIOR) && interior_ok) begin
      em_major = major_pos_r;
      em_minor = minor_acc_r;
      em_gap   = als_pkg::COV_W'(als_pkg::FULL_COV);
      em_last  = 1'b0;
    end else begin
      em_major = major_stop_r;
      em_minor = end_minor_r;
      em_gap   = end_gap_r;
      em_last  = 1'b1;
    end
  end

  als_pixel_emit u_emit (
    .major (em_major),
    .minor (em_minor),
    .gap   (em_gap),
    .steep (steep_r),
    .last  (em_last),
    .pair  (em_pair)
  );

  // sequencer next state
  always_comb begin
    st_nxt         = st_r;
    active_nxt     = active_r;
    phase_nxt      = phase_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    a1_nxt         = a1_r;
    m1_nxt         = m1_r;
    a2_nxt         = a2_r;
    m2_nxt         = m2_r;
    steep_nxt      = steep_r;
    neg_nxt        = neg_r;
    da_zero_nxt    = da_zero_r;
    slope_nxt      = slope_r;
    major_pos_nxt  = major_pos_r;
    major_stop_nxt = major_stop_r;
    minor_acc_nxt  = minor_acc_r;
    start_gap_nxt  = start_gap_r;
    end_minor_nxt  = end_minor_r;
    end_gap_nxt    = end_gap_r;
    pair_nxt       = pair_r;

    case (st_r)
      ST_RUN: begin
        if (load_fire) begin
          // old segment is dropped
          active_nxt = 1'b0;
          st_nxt     = ST_SORT;
        end else if (adv_fire && active_r) begin
          out_valid_nxt = 1'b1;
          pair_nxt      = em_pair;
          if (em_last) begin
            active_nxt = 1'b0;
            phase_nxt  = PH_END;
          end else begin
            minor_acc_nxt = minor_acc_r + als_pkg::MINOR_W'(slope_r);
            major_pos_nxt = major_pos_r + PIX_W'(1);
            phase_nxt     = PH_INTERIOR;
          end
        end
      end
      ST_SORT: begin
        steep_nxt = steep_c;
        if (sa2 < sa1) begin
          a1_nxt = sa2;
          m1_nxt = sm2;
          a2_nxt = sa1;
          m2_nxt = sm1;
        end else begin
          a1_nxt = sa1;
          m1_nxt = sm1;
          a2_nxt = sa2;
          m2_nxt = sm2;
        end
        st_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        neg_nxt     = dm_c[COORD_W];
        da_zero_nxt = (da_c == '0);
        st_nxt      = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          // coincident major coordinates give a gradient of one
          if (da_zero_r) begin
            slope_nxt = als_pkg::SLOPE_W'(1 << als_pkg::SLOPE_FRAC_BITS);
          end else begin
            slope_nxt = neg_r ? -quo_s : quo_s;
          end
          st_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        major_pos_nxt  = ep1_pix;
        minor_acc_nxt  = ep1_minor;
        start_gap_nxt  = ep1_gap;
        major_stop_nxt = ep2_pix;
        end_minor_nxt  = ep2_minor;
        end_gap_nxt    = ep2_gap;
        phase_nxt      = PH_START;
        active_nxt     = 1'b1;
        st_nxt         = ST_RUN;
      end
      default: begin
        st_nxt = ST_RUN;
      end
    endcase
  end

  // sequencer state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_RUN;
      active_r    <= 1'b0;
      phase_r     <= PH_START;
      out_valid_r <= 1'b0;
      pair_r      <= '0;
    end else begin
      st_r        <= st_nxt;
      active_r    <= active_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      pair_r      <= pair_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (load_fire) begin
      xs_r <= in_ch.x_start;
      ys_r <= in_ch.y_start;
      xe_r <= in_ch.x_end;
      ye_r <= in_ch.y_end;
    end
    a1_r         <= a1_nxt;
    m1_r         <= m1_nxt;
    a2_r         <= a2_nxt;
    m2_r         <= m2_nxt;
    steep_r      <= steep_nxt;
    neg_r        <= neg_nxt;
    da_zero_r    <= da_zero_nxt;
    slope_r      <= slope_nxt;
    major_pos_r  <= major_pos_nxt;
    major_stop_r <= major_stop_nxt;
    minor_acc_r  <= minor_acc_nxt;
    start_gap_r  <= start_gap_nxt;
    end_minor_r  <= end_minor_nxt;
    end_gap_r    <= end_gap_nxt;
  end

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.pixel_x         = pair_r.pixel_x;
  assign out_ch.pixel_y         = pair_r.pixel_y;
  assign out_ch.steep           = pair_r.steep;
  assign out_ch.coverage_first  = pair_r.coverage_first;
  assign out_ch.coverage_second = pair_r.coverage_second;
  assign out_ch.last            = pair_r.last;

  // no transaction is taken while the divider works
  `ALS_CHECK_IMP(a_no_accept_in_div, clk, rst_n, st_r == ST_DIV, !in_ch.ready)
  // a new pair only follows an accepted advance
  `ALS_CHECK_IMP(a_pair_from_advance, clk, rst_n, $rose(out_valid_r), $past(adv_fire))
  // stepping never runs more than one past the end pixel
  `ALS_CHECK_IMP(a_major_bound, clk, rst_n, active_r,
                 {1'b0, major_pos_r} <= ({1'b0, major_stop_r} + (PIX_W + 1)'(1)))
  // gradient magnitude stays within one when the major delta is nonzero
  `ALS_CHECK_IMP(a_quo_bound, clk, rst_n, div_rsp.done && !da_zero_r,
                 div_rsp.quo <= als_pkg::QUO_W'(1 << als_pkg::SLOPE_FRAC_BITS))

endmodule

### bench/als_line_checker.sv
// pixel pair predictor and scoreboard for the antialiased line stepper
`timescale 1ns / 100ps

module als_line_checker (
  input  logic clk,
  input  logic rst_n,
  als_in_if    in_ch,
  als_out_if   out_ch,
  output int   mismatches,
  output int   pairs_waiting,
  output int   pairs_checked,
  output int   loads_seen,
  output int   idle_advances
);

  localparam int CF       = als_pkg::COORD_FRAC_BITS;
  localparam int SF       = als_pkg::SLOPE_FRAC_BITS;
  localparam int CV       = als_pkg::COV_FRAC;
  localparam int FULL_COV = als_pkg::FULL_COV;

  typedef enum logic [1:0] {SEG_START, SEG_INTERIOR, SEG_END} seg_phase_t;

  // predicted segment state
  logic       seg_active;
  logic       seg_steep;
  seg_phase_t seg_phase;
  longint     major_at;
  longint     major_last;
  longint     minor_acc;
  longint     minor_last;
  longint     step;
  int         gap_first;
  int         gap_last;

  als_pkg::pair_t expected_pairs[$];

  int n_mismatch = 0;
  int n_checked  = 0;
  int n_loads    = 0;
  int n_idle     = 0;

  assign mismatches    = n_mismatch;
  assign pairs_waiting = expected_pairs.size();
  assign pairs_checked = n_checked;
  assign loads_seen    = n_loads;
  assign idle_advances = n_idle;

  task automatic report_mismatch(string what, int got, int want);
    n_mismatch++;
    $display("mismatch at pair %0d: %s got %0d want %0d", n_checked, what, got, want);
  endtask

  // rounded major pixel, minor position with slope fraction bits, end gap
  function automatic void place_endpoint(longint a, longint m, longint g, output longint pix,
                                         output longint minor, output int gap);
    longint half;
    longint rem;
    half  = longint'(1) << (CF - 1);
    pix   = (a + half) >>> CF;
    rem   = (a + half) & ((longint'(1) << CF) - 1);
    minor = m * (longint'(1) << (SF - CF)) + ((g * ((pix << CF) - a)) >>> CF);
    gap   = FULL_COV - int'(rem << (CV - CF));
  endfunction

  function automatic als_pkg::pair_t make_pair(logic steep, longint major, longint minor,
                                               int gap, logic is_last);
    als_pkg::pair_t p;
    longint         minor_pix;
    int             f;
    minor_pix = minor >>> SF;
    f = int'((minor & ((longint'(1) << SF) - 1)) >> (SF - CV));
    p.pixel_x         = steep ? als_pkg::pix_t'(minor_pix) : als_pkg::pix_t'(major);
    p.pixel_y         = steep ? als_pkg::pix_t'(major) : als_pkg::pix_t'(minor_pix);
    p.steep           = steep;
    p.coverage_first  = als_pkg::cov_t'(((FULL_COV - f) * gap) >> CV);
    p.coverage_second = als_pkg::cov_t'((f * gap) >> CV);
    p.last            = is_last;
    return p;
  endfunction

  task automatic load_segment(als_pkg::coord_t x_s, als_pkg::coord_t y_s,
                              als_pkg::coord_t x_e, als_pkg::coord_t y_e);
    longint xs, ys, xe, ye, adx, ady, a1, m1, a2, m2, t, da, dm, adm, g;
    xs = longint'(x_s);
    ys = longint'(y_s);
    xe = longint'(x_e);
    ye = longint'(y_e);
    adx = (xe >= xs) ? xe - xs : xs - xe;
    ady = (ye >= ys) ? ye - ys : ys - ye;
    seg_steep = (ady > adx);
    a1 = seg_steep ? ys : xs;
    m1 = seg_steep ? xs : ys;
    a2 = seg_steep ? ye : xe;
    m2 = seg_steep ? xe : ye;
    // order so the major coordinate rises
    if (a2 < a1) begin
      t = a1; a1 = a2; a2 = t;
      t = m1; m1 = m2; m2 = t;
    end
    da  = a2 - a1;
    dm  = m2 - m1;
    adm = (dm < 0) ? -dm : dm;
    if (da == 0) begin
      g = longint'(1) << SF;
    end else begin
      g = (adm << SF) / da;
      if (dm < 0) g = -g;
    end
    step = g;
    place_endpoint(a1, m1, g, major_at, minor_acc, gap_first);
    place_endpoint(a2, m2, g, major_last, minor_last, gap_last);
    seg_phase  = SEG_START;
    seg_active = 1'b1;
  endtask

  task automatic advance_segment();
    if (!seg_active) begin
      n_idle++;
    end else if (seg_phase == SEG_START) begin
      expected_pairs.push_back(make_pair(seg_steep, major_at, minor_acc, gap_first, 1'b0));
      minor_acc += step;
      major_at  += 1;
      seg_phase  = SEG_INTERIOR;
    end else if (seg_phase == SEG_INTERIOR && major_at < major_last) begin
      expected_pairs.push_back(make_pair(seg_steep, major_at, minor_acc, FULL_COV, 1'b0));
      minor_acc += step;
      major_at  += 1;
    end else begin
      expected_pairs.push_back(make_pair(seg_steep, major_last, minor_last, gap_last, 1'b1));
      seg_phase  = SEG_END;
      seg_active = 1'b0;
    end
  endtask

  task automatic compare_pair();
    als_pkg::pair_t want;
    if (expected_pairs.size() == 0) begin
      report_mismatch("pair with nothing expected, pixel_x", int'(out_ch.pixel_x), 0);
    end else begin
      want = expected_pairs.pop_front();
      if (out_ch.pixel_x !== want.pixel_x)
        report_mismatch("pixel_x", int'(out_ch.pixel_x), int'(want.pixel_x));
      if (out_ch.pixel_y !== want.pixel_y)
        report_mismatch("pixel_y", int'(out_ch.pixel_y), int'(want.pixel_y));
      if (out_ch.steep !== want.steep)
        report_mismatch("steep", int'(out_ch.steep), int'(want.steep));
      if (out_ch.coverage_first !== want.coverage_first)
        report_mismatch("coverage_first", int'(out_ch.coverage_first),
                        int'(want.coverage_first));
      if (out_ch.coverage_second !== want.coverage_second)
        report_mismatch("coverage_second", int'(out_ch.coverage_second),
                        int'(want.coverage_second));
      if (out_ch.last !== want.last)
        report_mismatch("last", int'(out_ch.last), int'(want.last));
    end
    n_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seg_active = 1'b0;
      seg_steep  = 1'b0;
      seg_phase  = SEG_START;
      major_at   = 0;
      major_last = 0;
      minor_acc  = 0;
      minor_last = 0;
      step       = 0;
      gap_first  = 0;
      gap_last   = 0;
      expected_pairs.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.func == als_pkg::FUNC_LOAD) begin
          n_loads++;
          load_segment(in_ch.x_start, in_ch.y_start, in_ch.x_end, in_ch.y_end);
        end else begin
          advance_segment();
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        compare_pair();
      end
    end
  end

endmodule

### bench/tb_antialiased_line_stepper_core.sv
// top of the antialiased line stepper testbench: stimulus, output stalls and verdict
`timescale 1ns / 100ps

module tb_antialiased_line_stepper_core;

  localparam int ITEM_GOAL     = 1200;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 250;
  localparam int RESET_CYCLES  = 5;
  localparam int CF            = als_pkg::COORD_FRAC_BITS;

  logic clk = 1'b0;
  logic rst_n;

  als_in_if  in_if ();
  als_out_if out_if ();

  int mismatches, pairs_waiting, pairs_checked, loads_seen, idle_advances;

  antialiased_line_stepper_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  als_line_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_if),
    .out_ch        (out_if),
    .mismatches    (mismatches),
    .pairs_waiting (pairs_waiting),
    .pairs_checked (pairs_checked),
    .loads_seen    (loads_seen),
    .idle_advances (idle_advances)
  );

  always #5 clk = ~clk;

  // watchdog: a correct run finishes far below this
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pairs still expected", cycle_count, pairs_waiting);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: out_ch.ready follows a pattern of its own; a toggle of
  // hold_trigger asks for one long hold-off, counted down here
  // ---------------------------------------------------------------------------
  logic hold_trigger = 1'b0;
  logic hold_seen    = 1'b0;
  int   hold_left    = 0;
  int   recv_mode    = 0;
  int   recv_left    = 0;
  int   recv_tick    = 0;

  always @(posedge clk) begin
    recv_tick++;
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left  = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      if (recv_left == 0) begin
        recv_mode = $urandom_range(0, 4);
        recv_left = $urandom_range(20, 200);
      end
      recv_left--;
      case (recv_mode)
        0: out_if.ready <= 1'b1;                           // no stalls at all
        1: out_if.ready <= ($urandom_range(0, 1) == 0);    // coin flip
        2: out_if.ready <= ($urandom_range(0, 9) != 0);    // rare stalls
        3: out_if.ready <= (recv_tick % 4 != 0);           // periodic bubble
        default: out_if.ready <= ($urandom_range(0, 4) == 0);  // mostly stalled
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sender: bursts of random length, random gaps in between
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  // offer one transaction and hold it until the block takes it
  task automatic offer(logic fn, als_pkg::coord_t xs, als_pkg::coord_t ys,
                       als_pkg::coord_t xe, als_pkg::coord_t ye);
    int gap;
    if (burst_left == 0) begin
      // roughly half the bursts follow on with no gap
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_if.valid   <= 1'b1;
    in_if.func    <= fn;
    in_if.x_start <= xs;
    in_if.y_start <= ys;
    in_if.x_end   <= xe;
    in_if.y_end   <= ye;
    do @(posedge clk); while (!in_if.ready);
    burst_left--;
  endtask

  task automatic load_seg(als_pkg::coord_t xs, als_pkg::coord_t ys,
                          als_pkg::coord_t xe, als_pkg::coord_t ye);
    offer(als_pkg::FUNC_LOAD, xs, ys, xe, ye);
  endtask

  // endpoint fields are don't-care on an advance, so they carry noise
  task automatic advance_n(int n);
    repeat (n) offer(als_pkg::FUNC_ADVANCE, als_pkg::coord_t'($urandom),
                     als_pkg::coord_t'($urandom), als_pkg::coord_t'($urandom),
                     als_pkg::coord_t'($urandom));
  endtask

  // stop offering until every predicted pair has come out
  task automatic wait_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pairs_waiting != 0);
    burst_left = 0;
  endtask

  // number of pairs a full walk of the segment gives, used to shape sequences
  function automatic int pairs_in_segment(als_pkg::coord_t xs, als_pkg::coord_t ys,
                                          als_pkg::coord_t xe, als_pkg::coord_t ye);
    int adx, ady, a1, a2, p1, p2, t;
    adx = (xe >= xs) ? int'(xe) - int'(xs) : int'(xs) - int'(xe);
    ady = (ye >= ys) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
    a1  = (ady > adx) ? int'(ys) : int'(xs);
    a2  = (ady > adx) ? int'(ye) : int'(xe);
    p1  = (a1 + (1 << (CF - 1))) >> CF;
    p2  = (a2 + (1 << (CF - 1))) >> CF;
    if (p1 > p2) begin
      t = p1; p1 = p2; p2 = t;
    end
    return ((p2 > p1) ? p2 - p1 : 1) + 1;
  endfunction

  function automatic als_pkg::coord_t nudge(als_pkg::coord_t base, int delta);
    int v;
    v = int'(base) + (($urandom_range(0, 1) == 0) ? delta : -delta);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return als_pkg::coord_t'(v);
  endfunction

  // mostly short segments anywhere on the grid, some medium, a few full range
  function automatic void random_segment(output als_pkg::coord_t xs,
                                         output als_pkg::coord_t ys,
                                         output als_pkg::coord_t xe,
                                         output als_pkg::coord_t ye);
    int pick, reach, dx, dy;
    pick  = $urandom_range(0, 99);
    reach = (pick < 70) ? 16 * 6 : (pick < 93) ? 16 * 40 : 65535;
    xs = als_pkg::coord_t'($urandom);
    ys = als_pkg::coord_t'($urandom);
    dx = $urandom_range(0, reach);
    dy = $urandom_range(0, reach);
    case ($urandom_range(0, 19))
      0: begin                // coincident endpoints
        xe = xs;
        ye = ys;
      end
      1: begin                // diagonal, gradient of magnitude one
        xe = nudge(xs, dx);
        ye = nudge(ys, dx);
      end
      2: begin                // axis aligned
        xe = nudge(xs, dx);
        ye = ys;
      end
      default: begin
        xe = nudge(xs, dx);
        ye = nudge(ys, dy);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    als_pkg::coord_t xs, ys, xe, ye;
    int              pick, count, adv;

    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.func    <= als_pkg::FUNC_LOAD;
    in_if.x_start <= '0;
    in_if.y_start <= '0;
    in_if.x_end   <= '0;
    in_if.y_end   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: advance with nothing loaded gives nothing
    advance_n(1);
    // coincident endpoints at the origin, one spare advance after the end pair
    load_seg(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    advance_n(3);
    // coincident endpoints at the top corner, pixel 4096
    load_seg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    advance_n(2);
    // falling shallow line whose end minor position goes below zero and wraps
    load_seg(16'h0000, 16'h0010, 16'h0028, 16'h0000);
    advance_n(4);
    // both endpoints round to the same major pixel
    load_seg(16'h0010, 16'h0020, 16'h0017, 16'h0025);
    advance_n(2);
    // steep line whose x coordinate falls as the major y coordinate rises
    load_seg(16'h0030, 16'h0000, 16'h0000, 16'h0038);
    advance_n(5);
    // reload while a segment is in flight drops the old one
    load_seg(16'h0000, 16'h0000, 16'h0100, 16'h0080);
    advance_n(1);
    load_seg(16'h0205, 16'h0ACE, 16'h0242, 16'h0A01);
    advance_n(pairs_in_segment(16'h0205, 16'h0ACE, 16'h0242, 16'h0A01));
    wait_drain();

    // back pressure: output held off while advances keep coming, so the
    // output register fills and the input side has to stall
    xs = 16'h0100;
    ys = 16'h0200;
    xe = als_pkg::coord_t'(16'h0100 + 16 * 90);
    ye = als_pkg::coord_t'(16'h0200 + 16 * 37);
    load_seg(xs, ys, xe, ye);
    hold_trigger <= ~hold_trigger;
    advance_n(pairs_in_segment(xs, ys, xe, ye));
    wait_drain();

    // random sequences: mostly full segment walks with random geometry,
    // some cut short by a reload, some stray transactions
    while (loads_seen + pairs_checked + pairs_waiting < ITEM_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        offer(logic'($urandom_range(0, 1)), als_pkg::coord_t'($urandom),
              als_pkg::coord_t'($urandom), als_pkg::coord_t'($urandom),
              als_pkg::coord_t'($urandom));
      end else begin
        random_segment(xs, ys, xe, ye);
        count = pairs_in_segment(xs, ys, xe, ye);
        load_seg(xs, ys, xe, ye);
        if (count > 60 || pick < 25) begin
          // cut short, the next load lands on an active segment
          adv = $urandom_range(0, (count > 40) ? 40 : count - 1);
        end else begin
          adv = count;
          if ($urandom_range(0, 4) == 0) adv += $urandom_range(1, 2);
        end
        advance_n(adv);
      end
      if ($urandom_range(0, 24) == 0) wait_drain();
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("summary: %0d segment loads, %0d pixel pairs compared, %0d idle advances",
             loads_seen, pairs_checked, idle_advances);
    $display("summary: corner, wrapped and same-pixel segments, reloads, %0d-cycle hold-off",
             LONG_HOLD);
    if (mismatches == 0 && pairs_waiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
